/* design/emcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emcc_pkg: shared types and constants
// Constants for the epoch millisecond calendar converter.
// ----------------------------------------------------------------------------
package emcc_pkg;

  localparam int unsigned EW = 44;
  localparam logic [EW-1:0] DAY_MS     = 44'd86400000;
  localparam logic [EW-1:0] YEAR_MS_C  = 44'd31536000000;
  localparam logic [EW-1:0] YEAR_MS_L  = 44'd31622400000;
  localparam logic [EW-1:0] HOUR_MS    = 44'd3600000;
  localparam logic [EW-1:0] MIN_MS     = 44'd60000;
  localparam logic [EW-1:0] SEC_MS     = 44'd1000;
  localparam logic [EW-1:0] EPOCH_MAX  = 44'hFFFFFFFFFFF;
  localparam logic [23:0]   MASK_C     = 24'hEEFBB3;
  localparam logic [23:0]   MASK_L     = 24'hEEFBB7;
  localparam logic [11:0]   FIRST_YEAR = 12'd1970;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_YEAR,
    ST_E_MONTH,
    ST_E_SUM,
    ST_D_YEAR,
    ST_D_MONTH,
    ST_D_DIV,
    ST_DONE
  } state_t;

endpackage

/* design/epoch_ms_calendar_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_ms_calendar_converter_unit
// Converts civil date and time to epoch milliseconds and back.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in_     | input     | in_valid, in_stall, request fields
//  out_    | output    | out_valid, out_stall, result fields
//
// One item at a time. Date to milliseconds: a year walk, then a month walk, then
// the day, hour, minute and second terms are added in turn. Milliseconds to
// date: a year walk bounded by LAST_YEAR, a month walk that stops at December,
// then restoring division one quotient bit per cycle for each of day, hour,
// minute and second. A bad year or month goes straight to the result. The
// result register holds while out_stall is high; in_stall is high from
// acceptance until the result is transferred.
// Reset clears the sequencer and out_valid.
module epoch_ms_calendar_converter_unit #(
  parameter int LAST_YEAR = 2399
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [43:0] in_epoch_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [43:0] out_epoch_out,
  output logic [11:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out,
  output logic        out_range_error
);

  localparam logic [13:0] LAST_Y = 14'(LAST_YEAR);

  emcc_pkg::state_t state_r, state_nxt;
  logic [12:0] year_r;
  logic [6:0]  yc100_r;
  logic [8:0]  yc400_r;
  logic [11:0] in_year_hold_r;
  logic [3:0]  mon_r, tgt_mon_r;
  logic [23:0] codes_r;
  logic [45:0] acc_r;
  logic [4:0]  day_r, hour_r;
  logic [5:0]  min_r, sec_r;
  logic [1:0]  field_r;
  logic [5:0]  bit_r;
  logic [43:0] quo_r;
  logic [43:0] rem_r;
  logic        out_valid_r;

  logic        leap;
  logic [43:0] ylen, mlen, divisor;
  logic [44:0] trial;
  logic [43:0] rnext;
  logic        qbit;
  logic [45:0] term;
  logic [45:0] sum;

  always_comb begin
    leap = (year_r[1:0] == 2'd0) && ((yc100_r != 7'd0) || (yc400_r == 9'd0));
    ylen = leap ? emcc_pkg::YEAR_MS_L : emcc_pkg::YEAR_MS_C;
    mlen = (44'd28 + {42'd0, codes_r[1:0]}) * emcc_pkg::DAY_MS;
    case (field_r)
      2'd0:    divisor = emcc_pkg::DAY_MS;
      2'd1:    divisor = emcc_pkg::HOUR_MS;
      2'd2:    divisor = emcc_pkg::MIN_MS;
      default: divisor = emcc_pkg::SEC_MS;
    endcase
    trial = {rem_r, acc_r[43]} - {1'b0, divisor};
    qbit  = !trial[44];
    rnext = trial[44] ? {rem_r[42:0], acc_r[43]} : trial[43:0];
    case (field_r)
      2'd0:    term = 46'(day_r) * 46'(emcc_pkg::DAY_MS) - 46'(emcc_pkg::DAY_MS);
      2'd1:    term = 46'(hour_r) * 46'(emcc_pkg::HOUR_MS);
      2'd2:    term = 46'(min_r) * 46'(emcc_pkg::MIN_MS);
      default: term = 46'(sec_r) * 46'(emcc_pkg::SEC_MS);
    endcase
    sum = acc_r + term;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      emcc_pkg::ST_IDLE:
        if (in_valid) begin
          if (in_req_type) state_nxt = emcc_pkg::ST_D_YEAR;
          else if (in_year < emcc_pkg::FIRST_YEAR || 14'(in_year) > LAST_Y ||
                   in_month == 4'd0 || in_month > 4'd12) state_nxt = emcc_pkg::ST_DONE;
          else state_nxt = emcc_pkg::ST_E_YEAR;
        end
      emcc_pkg::ST_E_YEAR:
        if (year_r == 13'(in_year_hold_r)) state_nxt = emcc_pkg::ST_E_MONTH;
      emcc_pkg::ST_E_MONTH:
        if (mon_r == tgt_mon_r) state_nxt = emcc_pkg::ST_E_SUM;
      emcc_pkg::ST_E_SUM:
        if (field_r == 2'd3) state_nxt = emcc_pkg::ST_DONE;
      emcc_pkg::ST_D_YEAR:
        if ({1'b0, year_r} > LAST_Y) state_nxt = emcc_pkg::ST_DONE;
        else if (acc_r[43:0] < ylen) state_nxt = emcc_pkg::ST_D_MONTH;
      emcc_pkg::ST_D_MONTH:
        if (mon_r == 4'd12 || acc_r[43:0] < mlen) state_nxt = emcc_pkg::ST_D_DIV;
      emcc_pkg::ST_D_DIV:
        if (bit_r == 6'd43 && field_r == 2'd3) state_nxt = emcc_pkg::ST_DONE;
      emcc_pkg::ST_DONE:
        if (!out_stall) state_nxt = emcc_pkg::ST_IDLE;
      default: state_nxt = emcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != emcc_pkg::ST_IDLE);
    out_valid = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= emcc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == emcc_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      emcc_pkg::ST_IDLE: begin
        year_r         <= 13'(emcc_pkg::FIRST_YEAR);
        yc100_r        <= 7'd70;
        yc400_r        <= 9'd370;
        mon_r          <= 4'd1;
        in_year_hold_r <= in_year;
        tgt_mon_r      <= in_month;
        day_r          <= in_day;
        hour_r         <= in_hour;
        min_r          <= in_minute;
        sec_r          <= in_second;
        acc_r          <= in_req_type ? {2'b00, in_epoch_in} : 46'd0;
        field_r        <= 2'd0;
        bit_r          <= 6'd0;
        rem_r          <= 44'd0;
        quo_r          <= 44'd0;
        out_epoch_out  <= 44'd0;
        out_year_out   <= 12'd0;
        out_month_out  <= 4'd0;
        out_day_out    <= 5'd0;
        out_hour_out   <= 5'd0;
        out_minute_out <= 6'd0;
        out_second_out <= 6'd0;
        out_range_error <= !in_req_type;
      end
      emcc_pkg::ST_E_YEAR: begin
        codes_r <= leap ? emcc_pkg::MASK_L : emcc_pkg::MASK_C;
        if (year_r != 13'(in_year_hold_r)) begin
          acc_r   <= acc_r + 46'(ylen);
          year_r  <= year_r + 13'd1;
          yc100_r <= (yc100_r == 7'd99) ? 7'd0 : yc100_r + 7'd1;
          yc400_r <= (yc400_r == 9'd399) ? 9'd0 : yc400_r + 9'd1;
        end
      end
      emcc_pkg::ST_E_MONTH:
        if (mon_r != tgt_mon_r) begin
          acc_r   <= acc_r + 46'(mlen);
          codes_r <= codes_r >> 2;
          mon_r   <= mon_r + 4'd1;
        end
      emcc_pkg::ST_E_SUM: begin
        field_r <= field_r + 2'd1;
        if (field_r != 2'd3) acc_r <= sum;
        else if (sum > 46'(emcc_pkg::EPOCH_MAX)) out_range_error <= 1'b1;
        else begin
          out_range_error <= 1'b0;
          out_epoch_out   <= sum[43:0];
        end
      end
      emcc_pkg::ST_D_YEAR: begin
        codes_r <= leap ? emcc_pkg::MASK_L : emcc_pkg::MASK_C;
        if ({1'b0, year_r} > LAST_Y) out_range_error <= 1'b1;
        else if (acc_r[43:0] >= ylen) begin
          acc_r   <= acc_r - 46'(ylen);
          year_r  <= year_r + 13'd1;
          yc100_r <= (yc100_r == 7'd99) ? 7'd0 : yc100_r + 7'd1;
          yc400_r <= (yc400_r == 9'd399) ? 9'd0 : yc400_r + 9'd1;
        end
      end
      emcc_pkg::ST_D_MONTH:
        if (mon_r != 4'd12 && acc_r[43:0] >= mlen) begin
          acc_r   <= acc_r - 46'(mlen);
          codes_r <= codes_r >> 2;
          mon_r   <= mon_r + 4'd1;
        end else begin
          out_range_error <= 1'b0;
          out_year_out    <= year_r[11:0];
          out_month_out   <= mon_r;
        end
      emcc_pkg::ST_D_DIV: begin
        if (bit_r == 6'd43) begin
          bit_r   <= 6'd0;
          field_r <= field_r + 2'd1;
          acc_r   <= {2'b00, rnext};
          rem_r   <= 44'd0;
          quo_r   <= 44'd0;
          case (field_r)
            2'd0:    out_day_out    <= 5'({quo_r[4:0], qbit} + 6'd1);
            2'd1:    out_hour_out   <= {quo_r[3:0], qbit};
            2'd2:    out_minute_out <= {quo_r[4:0], qbit};
            default: out_second_out <= {quo_r[4:0], qbit};
          endcase
        end else begin
          bit_r <= bit_r + 6'd1;
          acc_r <= {acc_r[45:44], acc_r[42:0], 1'b0};
          rem_r <= rnext;
          quo_r <= {quo_r[42:0], qbit};
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/emcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emcc_checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module emcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [43:0] out_epoch_out,
  input logic [11:0] out_year_out,
  input logic        out_range_error
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_epoch_out))
    else $error("result dropped under stall");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_epoch_out == 44'd0 && out_year_out == 12'd0)
    else $error("error result carries data");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer while busy");

endmodule

bind epoch_ms_calendar_converter_unit emcc_checker u_emcc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_epoch_out(out_epoch_out),
  .out_year_out(out_year_out), .out_range_error(out_range_error)
);

/* tb/sv/epoch_ms_calendar_converter_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_ms_calendar_converter_unit_tb
// Self-checking bench for the epoch millisecond calendar converter. A short
// table of directed requests (range edges, bad years and months, day zero,
// counts past the last year) is followed by random requests in both
// directions. Each result is checked against the row's stated value, else a
// software calendar model. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module epoch_ms_calendar_converter_unit_tb;

  localparam int          TOP_YEAR   = 2399;
  localparam longint      SPAN_MS    = 64'd13569465600000;
  localparam int          RAND_ITEMS = 1530;
  localparam int          CYC_LIMIT  = 4000000;

  typedef struct packed {
    logic        req;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [43:0] ms;
  } request_t;

  typedef struct packed {
    logic [43:0] ms;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        err;
  } civil_t;

  typedef struct {
    request_t rq;
    bit       typed;
    civil_t   res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic [43:0] in_epoch_in;
  logic        out_valid;
  logic        out_stall;
  logic [43:0] out_epoch_out;
  logic [11:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [4:0]  out_hour_out;
  logic [5:0]  out_minute_out;
  logic [5:0]  out_second_out;
  logic        out_range_error;

  civil_t pending_q[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     calm = 0;
  row_t   rows[$];

  epoch_ms_calendar_converter_unit #(.LAST_YEAR(TOP_YEAR)) DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_leap(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint year_ms(int y);
    return is_leap(y) ? longint'(emcc_pkg::YEAR_MS_L) : longint'(emcc_pkg::YEAR_MS_C);
  endfunction

  function automatic civil_t convert(request_t rq);
    civil_t      r;
    longint      acc;
    logic [23:0] codes;
    int          y;
    int          m;
    r = '0;
    if (!rq.req) begin
      if (rq.year < emcc_pkg::FIRST_YEAR || rq.year > TOP_YEAR || rq.month < 1 ||
          rq.month > 12) begin
        r.err = 1;
        return r;
      end
      acc = 0;
      for (y = int'(emcc_pkg::FIRST_YEAR); y < rq.year; y++) acc += year_ms(y);
      codes = is_leap(int'(rq.year)) ? emcc_pkg::MASK_L : emcc_pkg::MASK_C;
      for (m = 1; m < rq.month; m++) begin
        acc += (28 + codes[1:0]) * longint'(emcc_pkg::DAY_MS);
        codes = codes >> 2;
      end
      acc += 1000 * (longint'(rq.second) + 60 * (longint'(rq.minute) + 60 *
             (longint'(rq.hour) + (longint'(rq.day) - 1) * 24)));
      if (acc < 0 || acc > longint'(emcc_pkg::EPOCH_MAX)) r.err = 1;
      else r.ms = acc[43:0];
    end else begin
      acc = longint'(rq.ms);
      y = int'(emcc_pkg::FIRST_YEAR);
      while (y <= TOP_YEAR && acc >= year_ms(y)) begin
        acc -= year_ms(y);
        y++;
      end
      if (y > TOP_YEAR) begin
        r.err = 1;
        return r;
      end
      codes = is_leap(y) ? emcc_pkg::MASK_L : emcc_pkg::MASK_C;
      m = 1;
      while (m < 12 && acc >= (28 + codes[1:0]) * longint'(emcc_pkg::DAY_MS)) begin
        acc -= (28 + codes[1:0]) * longint'(emcc_pkg::DAY_MS);
        codes = codes >> 2;
        m++;
      end
      r.year   = 12'(y);
      r.month  = 4'(m);
      r.day    = 5'(acc / longint'(emcc_pkg::DAY_MS) + 1);
      acc      = acc % longint'(emcc_pkg::DAY_MS);
      r.hour   = 5'(acc / 3600000);
      acc      = acc % 3600000;
      r.minute = 6'(acc / 60000);
      r.second = 6'((acc % 60000) / 1000);
    end
    return r;
  endfunction

  function automatic request_t mk(logic req, int y, int mo, int d, int h, int mi, int s,
                                  longint e);
    request_t rq;
    rq.req = req;
    rq.year = 12'(y);
    rq.month = 4'(mo);
    rq.day = 5'(d);
    rq.hour = 5'(h);
    rq.minute = 6'(mi);
    rq.second = 6'(s);
    rq.ms = 44'(e);
    return rq;
  endfunction

  function automatic civil_t date_res(int y, int mo, int d, int h, int mi, int s);
    civil_t r;
    r = '0;
    r.year = 12'(y);
    r.month = 4'(mo);
    r.day = 5'(d);
    r.hour = 5'(h);
    r.minute = 6'(mi);
    r.second = 6'(s);
    return r;
  endfunction

  function automatic civil_t ms_res(longint e);
    civil_t r;
    r = '0;
    r.ms = 44'(e);
    return r;
  endfunction

  function automatic civil_t err_res();
    civil_t r;
    r = '0;
    r.err = 1;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t    rq;
    logic [63:0] w;
    rq = request_t'(83'({$urandom, $urandom, $urandom}));
    rq.req = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) != 0) begin
      rq.year   = 12'($urandom_range(0, 9) == 0 ? $urandom_range(1970, 1990)
                                                : $urandom_range(1970, TOP_YEAR));
      rq.month  = 4'($urandom_range(1, 12));
      rq.day    = 5'($urandom_range(1, 31));
      rq.hour   = 5'($urandom_range(0, 23));
      rq.minute = 6'($urandom_range(0, 59));
      rq.second = 6'($urandom_range(0, 59));
      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: rq.ms = 44'(SPAN_MS - 1 - longint'($urandom_range(0, 100000)));
        1: rq.ms = 44'(SPAN_MS + longint'($urandom_range(0, 100000)));
        default: rq.ms = 44'(w % SPAN_MS);
      endcase
    end
    return rq;
  endfunction

  task automatic send(request_t rq, bit typed, civil_t res);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rq.req;
    in_year     <= rq.year;
    in_month    <= rq.month;
    in_day      <= rq.day;
    in_hour     <= rq.hour;
    in_minute   <= rq.minute;
    in_second   <= rq.second;
    in_epoch_in <= rq.ms;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    pending_q.push_back(typed ? res : convert(rq));
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= 1'b0;
    in_year     <= '0;
    in_month    <= '0;
    in_day      <= '0;
    in_hour     <= '0;
    in_minute   <= '0;
    in_second   <= '0;
    in_epoch_in <= '0;
    rows = '{
      '{mk(0, 1970, 1, 1, 0, 0, 0, 0), 1, ms_res(0)},
      '{mk(1, 0, 0, 0, 0, 0, 0, 0), 1, date_res(1970, 1, 1, 0, 0, 0)},
      '{mk(1, 0, 0, 0, 0, 0, 0, 999), 1, date_res(1970, 1, 1, 0, 0, 0)},
      '{mk(1, 0, 0, 0, 0, 0, 0, 64'd13569465599999), 1, date_res(2399, 12, 31, 23, 59, 59)},
      '{mk(1, 0, 0, 0, 0, 0, 0, 64'd13569465600000), 1, err_res()},
      '{mk(1, 0, 0, 0, 0, 0, 0, 64'hFFFFFFFFFFF), 1, err_res()},
      '{mk(0, 1969, 12, 31, 23, 59, 59, 0), 1, err_res()},
      '{mk(0, 2400, 1, 1, 0, 0, 0, 0), 1, err_res()},
      '{mk(0, 4095, 15, 31, 31, 63, 63, 0), 1, err_res()},
      '{mk(0, 2000, 0, 1, 0, 0, 0, 0), 1, err_res()},
      '{mk(0, 2000, 13, 1, 0, 0, 0, 0), 1, err_res()},
      '{mk(0, 1970, 1, 0, 0, 0, 0, 0), 1, err_res()},
      '{mk(0, 2000, 1, 1, 0, 0, 0, 0), 1, ms_res(64'd946684800000)},
      '{mk(0, 2399, 12, 31, 23, 59, 59, 0), 1, ms_res(64'd13569465599000)},
      '{mk(0, 1970, 1, 0, 23, 59, 59, 0), 0, '0},
      '{mk(0, 2399, 12, 31, 31, 63, 63, 0), 0, '0},
      '{mk(0, 2000, 2, 29, 12, 0, 0, 0), 0, '0},
      '{mk(0, 2100, 2, 29, 0, 0, 0, 0), 0, '0},
      '{mk(0, 1996, 12, 31, 0, 0, 0, 0), 0, '0},
      '{mk(1, 0, 0, 0, 0, 0, 0, 64'd951782400000), 0, '0},
      '{mk(1, 0, 0, 0, 0, 0, 0, 64'd4107542399999), 0, '0},
      '{mk(1, 4095, 15, 31, 31, 63, 63, 64'd12622780800000), 0, '0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].rq, rows[i].typed, rows[i].res);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 100) calm = ~calm;
      if (n == RAND_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (10) @(posedge clk);
      end
      send(random_request(), 0, '0);
    end
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    int     hold;
    civil_t got;
    civil_t exp_res;
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      got = {out_epoch_out, out_year_out, out_month_out, out_day_out, out_hour_out,
             out_minute_out, out_second_out, out_range_error};
      @(posedge clk);
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        exp_res = pending_q.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_res, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
